// ===== sv/lsa_pkg.sv =====
`timescale 1ns / 1ps

package lsa_pkg;

  localparam int unsigned BANKS     = 3;
  localparam int unsigned SLOTS     = 4;
  localparam int unsigned BANK_W    = 2;
  localparam int unsigned SLOT_W    = 2;
  localparam logic [15:0] WINDOW_RST = 16'd5000;
  localparam logic [7:0]  BRIGHT_MAX = 8'd5;

  // register indexes on the configuration port
  localparam logic REG_FRESH_WINDOW = 1'b0;

  typedef logic [BANK_W-1:0] bank_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // one arbitration tick
  typedef struct packed {
    logic [31:0] now_ms;
    logic        modern_present;
    logic [7:0]  modern_color;
    logic [7:0]  modern_brightness;
    logic [7:0]  modern_effect;
    logic [31:0] modern_stamp;
    logic        legacy_present;
    logic [7:0]  legacy_color_code;
    logic [15:0] legacy_level_q8;
  } tick_t;

  // one light update
  typedef struct packed {
    logic [7:0]  light_colour;
    logic [7:0]  brightness_out;
    logic [7:0]  effect_out;
    logic        from_legacy;
    logic [31:0] update_time;
  } upd_t;

  // bank cycler state
  typedef struct packed {
    logic                  started;
    bank_t                 cur_bank;
    slot_t [BANKS-1:0]     slot;
  } cyc_t;

  // fixed colour table, banks by slots
  function automatic logic [7:0] color_lookup(input bank_t bank, input slot_t slot);
    logic [7:0] c;
    c = 8'd0;
    case ({bank, slot})
      4'b00_00: c = 8'd1;
      4'b00_01: c = 8'd0;
      4'b00_10: c = 8'd2;
      4'b00_11: c = 8'd3;
      4'b01_00: c = 8'd11;
      4'b01_01: c = 8'd10;
      4'b01_10: c = 8'd6;
      4'b01_11: c = 8'd5;
      4'b10_00: c = 8'd8;
      4'b10_01: c = 8'd7;
      4'b10_10: c = 8'd6;
      4'b10_11: c = 8'd9;
      default:  c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/lsa_decide.sv =====
`timescale 1ns / 1ps

module lsa_decide (
  input  lsa_pkg::tick_t tick,
  input  logic [15:0]    window,
  input  lsa_pkg::cyc_t  cyc,
  output logic           hit,
  output lsa_pkg::upd_t  upd,
  output logic           cyc_we,
  output lsa_pkg::cyc_t  cyc_nxt
);

  logic [31:0]          age;
  logic                 fresh;
  logic                 use_modern;
  logic [3:0]           dsum;
  logic [2:0]           dsum2;
  lsa_pkg::bank_t       bank;
  lsa_pkg::slot_t       slot_sel;
  logic [18:0]          scaled;
  logic [10:0]          br_raw;
  logic [7:0]           br;

  // freshness of the modern request
  assign age   = tick.now_ms - tick.modern_stamp;
  assign fresh = (tick.modern_stamp != 32'd0) && (tick.modern_stamp <= tick.now_ms) &&
                 (age <= {16'd0, window});
  assign use_modern = tick.modern_present && fresh;

  // legacy code mod 3 through base-4 digit sums
  assign dsum  = {2'b00, tick.legacy_color_code[7:6]} + {2'b00, tick.legacy_color_code[5:4]} +
                 {2'b00, tick.legacy_color_code[3:2]} + {2'b00, tick.legacy_color_code[1:0]};
  assign dsum2 = {1'b0, dsum[3:2]} + {1'b0, dsum[1:0]};
  always_comb begin
    if (dsum2 >= 3'd6) begin
      bank = lsa_pkg::bank_t'(dsum2 - 3'd6);
    end else if (dsum2 >= 3'd3) begin
      bank = lsa_pkg::bank_t'(dsum2 - 3'd3);
    end else begin
      bank = lsa_pkg::bank_t'(dsum2);
    end
  end

  // bank cycler
  always_comb begin
    cyc_nxt  = cyc;
    slot_sel = cyc.slot[bank];
    if (!cyc.started) begin
      cyc_nxt.started  = 1'b1;
      cyc_nxt.cur_bank = bank;
    end else if (cyc.cur_bank != bank) begin
      slot_sel              = cyc.slot[bank] + 2'd1;
      cyc_nxt.slot[bank]    = slot_sel;
      cyc_nxt.cur_bank      = bank;
    end
  end

  // brightness: round level*5 half up, saturate at 5
  assign scaled = {1'b0, tick.legacy_level_q8, 2'b00} + {3'b000, tick.legacy_level_q8} + 19'd128;
  assign br_raw = scaled[18:8];
  assign br     = (br_raw > 11'd5) ? lsa_pkg::BRIGHT_MAX : br_raw[7:0];

  // source selection
  always_comb begin
    hit    = 1'b0;
    cyc_we = 1'b0;
    upd.update_time = tick.now_ms;
    if (use_modern) begin
      hit                = 1'b1;
      upd.light_colour   = tick.modern_color;
      upd.brightness_out = tick.modern_brightness;
      upd.effect_out     = tick.modern_effect;
      upd.from_legacy    = 1'b0;
    end else begin
      hit                = tick.legacy_present;
      cyc_we             = tick.legacy_present;
      upd.light_colour   = lsa_pkg::color_lookup(bank, slot_sel);
      upd.brightness_out = br;
      upd.effect_out     = 8'd0;
      upd.from_legacy    = 1'b1;
    end
  end

endmodule

// ===== sv/lighting_source_arbiter_top.sv =====
`timescale 1ns / 1ps
// lighting source arbiter
// input channel: one beat per arbitration tick (time, modern request, legacy
// message), taken when in_valid is high and in_stall is low.
// output channel: at most one light update per tick, presented on out_valid
// and held while out_stall is high. a tick in which neither source applies
// gives no beat.
// path: a tick is registered on entry, and its update moves on into the output
// register once that register is free or draining.
// throughput: one tick per cycle while out_stall is low; the whole decision is
// a single pass of compare and small arithmetic between entry and output registers.
// when the receiver stalls, the output register holds its beat and the entry
// register fills; in_stall rises only once both are occupied.
// configuration: apb write to byte address 0 sets fresh_window_ms; write it
// only while no tick is in flight.
// reset: empties both registers, restores a window of 5000 ms and clears the
// bank cycler (not started, bank 0, every slot 0).

module lighting_source_arbiter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_modern_present,
  input  logic [7:0]  in_modern_color,
  input  logic [7:0]  in_modern_brightness,
  input  logic [7:0]  in_modern_effect,
  input  logic [31:0] in_modern_stamp,
  input  logic        in_legacy_present,
  input  logic [7:0]  in_legacy_color_code,
  input  logic [15:0] in_legacy_level_q8,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_light_colour,
  output logic [7:0]  out_brightness_out,
  output logic [7:0]  out_effect_out,
  output logic        out_from_legacy,
  output logic [31:0] out_update_time,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic            s1_valid_r;
  lsa_pkg::tick_t  s1_tick_r;
  logic            s1_adv;
  logic            out_valid_r;
  lsa_pkg::upd_t   out_upd_r;
  logic [15:0]     window_r;
  lsa_pkg::cyc_t   cyc_r;
  logic            hit;
  lsa_pkg::upd_t   upd;
  logic            cyc_we;
  lsa_pkg::cyc_t   cyc_nxt;
  logic            cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == lsa_pkg::REG_FRESH_WINDOW) ? {16'd0, window_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= lsa_pkg::WINDOW_RST;
    end else if (cfg_wr && (cfg_paddr[2] == lsa_pkg::REG_FRESH_WINDOW)) begin
      window_r <= cfg_pwdata[15:0];
    end
  end

  // handshake: entry stage moves on when the output register is free or draining
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_tick_r.now_ms            <= in_now_ms;
      s1_tick_r.modern_present    <= in_modern_present;
      s1_tick_r.modern_color      <= in_modern_color;
      s1_tick_r.modern_brightness <= in_modern_brightness;
      s1_tick_r.modern_effect     <= in_modern_effect;
      s1_tick_r.modern_stamp      <= in_modern_stamp;
      s1_tick_r.legacy_present    <= in_legacy_present;
      s1_tick_r.legacy_color_code <= in_legacy_color_code;
      s1_tick_r.legacy_level_q8   <= in_legacy_level_q8;
    end
  end

  // decision logic
  lsa_decide u_decide (
    .tick    (s1_tick_r),
    .window  (window_r),
    .cyc     (cyc_r),
    .hit     (hit),
    .upd     (upd),
    .cyc_we  (cyc_we),
    .cyc_nxt (cyc_nxt)
  );

  // bank cycler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyc_r <= '0;
    end else if (s1_valid_r && s1_adv && cyc_we) begin
      cyc_r <= cyc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r && hit) begin
      out_upd_r <= upd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_light_colour   = out_upd_r.light_colour;
  assign out_brightness_out = out_upd_r.brightness_out;
  assign out_effect_out     = out_upd_r.effect_out;
  assign out_from_legacy    = out_upd_r.from_legacy;
  assign out_update_time    = out_upd_r.update_time;

endmodule

// ===== tb/tb_lighting_source_arbiter_top.sv =====
`timescale 1ns / 1ps

module tb_lighting_source_arbiter_top;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 6;

  // byte addresses on the configuration port
  localparam logic [2:0] WINDOW_ADDR = {lsa_pkg::REG_FRESH_WINDOW, 2'b00};
  localparam logic [2:0] SPARE_ADDR  = 3'd4;

  // colour banks, indexed by bank then slot
  localparam logic [7:0] COLOUR_TABLE [0:2][0:3] = '{
    '{8'd1,  8'd0,  8'd2, 8'd3},
    '{8'd11, 8'd10, 8'd6, 8'd5},
    '{8'd8,  8'd7,  8'd6, 8'd9}
  };

  // how a scripted row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_UPD} row_chk_t;

  typedef struct {
    lsa_pkg::tick_t t;
    row_chk_t       chk;
    lsa_pkg::upd_t  u;
  } script_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_now_ms = '0;
  logic        in_modern_present = 1'b0;
  logic [7:0]  in_modern_color = '0;
  logic [7:0]  in_modern_brightness = '0;
  logic [7:0]  in_modern_effect = '0;
  logic [31:0] in_modern_stamp = '0;
  logic        in_legacy_present = 1'b0;
  logic [7:0]  in_legacy_color_code = '0;
  logic [15:0] in_legacy_level_q8 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_light_colour;
  logic [7:0]  out_brightness_out;
  logic [7:0]  out_effect_out;
  logic        out_from_legacy;
  logic [31:0] out_update_time;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predicted arbiter state
  logic [15:0]     window_ms = lsa_pkg::WINDOW_RST;
  logic            cyc_started = 1'b0;
  lsa_pkg::bank_t  cyc_bank = '0;
  lsa_pkg::slot_t  cyc_slot [lsa_pkg::BANKS] = '{default: '0};

  lsa_pkg::upd_t light_q [$];
  lsa_pkg::upd_t head_u;
  int            errors = 0;
  int            ticks_sent = 0;
  int            updates_seen = 0;
  int            sender_idle_pct = 0;
  int            recv_stall_pct = 0;
  int unsigned   quiet = 0;

  lighting_source_arbiter_top uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // arbitration of one tick against the predicted state
  function automatic bit arbitrate(input lsa_pkg::tick_t t, output lsa_pkg::upd_t u);
    lsa_pkg::bank_t b;
    logic [19:0]    lvl;
    u = '0;
    u.update_time = t.now_ms;
    if (t.modern_present && t.modern_stamp != 32'd0 && t.modern_stamp <= t.now_ms &&
        (t.now_ms - t.modern_stamp) <= {16'd0, window_ms}) begin
      u.light_colour   = t.modern_color;
      u.brightness_out = t.modern_brightness;
      u.effect_out     = t.modern_effect;
      u.from_legacy    = 1'b0;
      return 1'b1;
    end
    if (!t.legacy_present)
      return 1'b0;
    b = lsa_pkg::bank_t'(t.legacy_color_code % 8'd3);
    // first legacy tick only latches the bank
    if (!cyc_started) begin
      cyc_started = 1'b1;
      cyc_bank    = b;
    end else if (cyc_bank != b) begin
      cyc_slot[b] = cyc_slot[b] + 2'd1;
      cyc_bank    = b;
    end
    // round level*5 half up, saturate at full
    lvl = ({4'd0, t.legacy_level_q8} * 20'd5 + 20'd128) >> 8;
    u.light_colour   = COLOUR_TABLE[b][cyc_slot[b]];
    u.brightness_out = (lvl > 20'd5) ? lsa_pkg::BRIGHT_MAX : lvl[7:0];
    u.effect_out     = 8'd0;
    u.from_legacy    = 1'b1;
    return 1'b1;
  endfunction

  function automatic lsa_pkg::tick_t tk(input logic [31:0] now, input logic mp,
                                        input logic [7:0] mc, input logic [7:0] mb,
                                        input logic [7:0] me, input logic [31:0] stamp,
                                        input logic lp, input logic [7:0] code,
                                        input logic [15:0] level);
    lsa_pkg::tick_t t;
    t.now_ms            = now;
    t.modern_present    = mp;
    t.modern_color      = mc;
    t.modern_brightness = mb;
    t.modern_effect     = me;
    t.modern_stamp      = stamp;
    t.legacy_present    = lp;
    t.legacy_color_code = code;
    t.legacy_level_q8   = level;
    return t;
  endfunction

  function automatic lsa_pkg::upd_t up(input logic [7:0] c, input logic [7:0] br,
                                       input logic [7:0] eff, input logic leg,
                                       input logic [31:0] tm);
    lsa_pkg::upd_t u;
    u.light_colour   = c;
    u.brightness_out = br;
    u.effect_out     = eff;
    u.from_legacy    = leg;
    u.update_time    = tm;
    return u;
  endfunction

  // random tick, stamps mostly within the freshness window, some just outside either edge
  function automatic lsa_pkg::tick_t rand_tick();
    lsa_pkg::tick_t t;
    logic [31:0]    span;
    span = {16'd0, window_ms};
    t.now_ms            = ($urandom_range(3) == 0) ? 32'($urandom_range(20000)) : $urandom;
    t.modern_present    = ($urandom_range(9) < 7);
    t.modern_color      = 8'($urandom);
    t.modern_brightness = 8'($urandom);
    t.modern_effect     = 8'($urandom);
    case ($urandom_range(9))
      0:       t.modern_stamp = 32'd0;
      1:       t.modern_stamp = $urandom;
      2:       t.modern_stamp = t.now_ms + 32'($urandom_range(3)) + 32'd1;
      3:       t.modern_stamp = t.now_ms - span - 32'($urandom_range(3)) - 32'd1;
      default: t.modern_stamp = t.now_ms - 32'($urandom_range(span));
    endcase
    t.legacy_present    = ($urandom_range(3) != 0);
    t.legacy_color_code = 8'($urandom);
    t.legacy_level_q8   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(300));
    return t;
  endfunction

  // present one tick, hold it until taken, then log what it should produce
  task automatic send_tick(input lsa_pkg::tick_t t, input row_chk_t chk,
                           input lsa_pkg::upd_t typed);
    lsa_pkg::upd_t u;
    bit            has;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_now_ms            <= t.now_ms;
    in_modern_present    <= t.modern_present;
    in_modern_color      <= t.modern_color;
    in_modern_brightness <= t.modern_brightness;
    in_modern_effect     <= t.modern_effect;
    in_modern_stamp      <= t.modern_stamp;
    in_legacy_present    <= t.legacy_present;
    in_legacy_color_code <= t.legacy_color_code;
    in_legacy_level_q8   <= t.legacy_level_q8;
    do @(posedge clk); while (in_stall !== 1'b0);
    has = arbitrate(t, u);
    ticks_sent++;
    if (chk == CHK_UPD)
      light_q.push_back(typed);
    else if (chk == CHK_MODEL && has)
      light_q.push_back(u);
  endtask

  // let every outstanding tick leave the pipe
  task automatic drain();
    in_valid <= 1'b0;
    while (light_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one apb transfer, setup then access, then the bus left idle
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // register write followed by a readback of the window
  task automatic set_register(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, data, rd);
    if (addr == WINDOW_ADDR)
      window_ms = data[15:0];
    apb_xfer(1'b0, WINDOW_ADDR, 32'd0, rd);
    if (rd !== {16'd0, window_ms}) begin
      $display("%0t window readback: expected %h actual %h", $time, {16'd0, window_ms}, rd);
      errors++;
    end
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    repeat (n) send_tick(rand_tick(), CHK_MODEL, '0);
    drain();
  endtask

  task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each update beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      updates_seen++;
      if (light_q.size() == 0) begin
        $display("%0t unexpected update beat: expected none actual colour %h time %h",
                 $time, out_light_colour, out_update_time);
        errors++;
      end else begin
        head_u = light_q.pop_front();
        field_check("light_colour", 32'(head_u.light_colour), 32'(out_light_colour));
        field_check("brightness_out", 32'(head_u.brightness_out), 32'(out_brightness_out));
        field_check("effect_out", 32'(head_u.effect_out), 32'(out_effect_out));
        field_check("from_legacy", 32'(head_u.from_legacy), 32'(out_from_legacy));
        field_check("update_time", head_u.update_time, out_update_time);
      end
    end
  end

  // watchdog on cycles without any beat moving
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("FAIL lighting_source_arbiter_top");
      $finish;
    end
  end

  initial begin
    script_row_t script [$];

    // scripted ticks, window at its reset value
    script.push_back('{tk(100, 0, 0, 0, 0, 0, 0, 0, 0), CHK_NONE, '0});
    // zero stamp means no request
    script.push_back('{tk(1000, 1, 8'h12, 8'h34, 8'h56, 0, 0, 0, 0), CHK_NONE, '0});
    // stamp equal to now is fresh
    script.push_back('{tk(1000, 1, 8'hFF, 8'hFF, 8'hFF, 1000, 0, 0, 0), CHK_UPD,
                       up(8'hFF, 8'hFF, 8'hFF, 1'b0, 1000)});
    // age exactly the window
    script.push_back('{tk(6000, 1, 0, 0, 0, 1000, 0, 0, 0), CHK_UPD, up(0, 0, 0, 1'b0, 6000)});
    // one past the window, first legacy tick latches bank 0
    script.push_back('{tk(6001, 1, 8'hFF, 8'hFF, 8'hFF, 1000, 1, 0, 0), CHK_UPD,
                       up(1, 0, 0, 1'b1, 6001)});
    // stamp in the future
    script.push_back('{tk(10, 1, 8'hFF, 8'hFF, 8'hFF, 11, 1, 0, 256), CHK_UPD,
                       up(1, 5, 0, 1'b1, 10)});
    // all-ones fields, modern absent, level saturates
    script.push_back('{tk(32'hFFFF_FFFF, 0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1, 8'hFF,
                          16'hFFFF), CHK_UPD, up(1, 5, 0, 1'b1, 32'hFFFF_FFFF)});
    // bank change advances the new bank's slot
    script.push_back('{tk(20, 0, 0, 0, 0, 0, 1, 1, 128), CHK_UPD, up(10, 3, 0, 1'b1, 20)});
    script.push_back('{tk(21, 0, 0, 0, 0, 0, 1, 1, 52), CHK_UPD, up(10, 1, 0, 1'b1, 21)});
    script.push_back('{tk(22, 0, 0, 0, 0, 0, 1, 2, 26), CHK_MODEL, '0});
    script.push_back('{tk(23, 0, 0, 0, 0, 0, 1, 0, 25), CHK_MODEL, '0});
    // modern wins over legacy, cycler untouched
    script.push_back('{tk(24, 1, 8'hAA, 8'h55, 8'hC3, 24, 1, 4, 230), CHK_MODEL, '0});
    script.push_back('{tk(25, 0, 0, 0, 0, 0, 1, 4, 230), CHK_MODEL, '0});
    script.push_back('{tk(26, 0, 0, 0, 0, 0, 1, 5, 231), CHK_MODEL, '0});
    script.push_back('{tk(27, 0, 0, 0, 0, 0, 1, 3, 51), CHK_MODEL, '0});
    script.push_back('{tk(28, 0, 0, 0, 0, 0, 1, 7, 300), CHK_MODEL, '0});
    script.push_back('{tk(29, 0, 0, 0, 0, 0, 1, 8, 16'hFFFF), CHK_MODEL, '0});
    script.push_back('{tk(30, 0, 0, 0, 0, 0, 1, 9, 1000), CHK_MODEL, '0});
    // slot wraps back to zero
    script.push_back('{tk(31, 0, 0, 0, 0, 0, 1, 10, 0), CHK_MODEL, '0});
    script.push_back('{tk(32'h8000_0000, 1, 1, 2, 3, 32'h7FFF_EC78, 0, 0, 0), CHK_MODEL, '0});
    script.push_back('{tk(40, 1, 8'h0F, 8'hF0, 8'h3C, 0, 1, 8'hFE, 128), CHK_MODEL, '0});

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i])
      send_tick(script[i].t, script[i].chk, script[i].u);
    drain();

    // random ticks over several windows and handshake mixes
    run_phase(400, 0, 0);
    set_register(WINDOW_ADDR, 32'hFFFF_0000);
    run_phase(300, 85, 0);
    set_register(WINDOW_ADDR, 32'h0000_FFFF);
    run_phase(300, 0, 85);
    // write past the register list is dropped
    set_register(SPARE_ADDR, $urandom);
    set_register(WINDOW_ADDR, 32'd1);
    run_phase(400, 22, 22);
    set_register(WINDOW_ADDR, $urandom);
    run_phase(300, 0, 0);
    set_register(WINDOW_ADDR, {16'd0, lsa_pkg::WINDOW_RST});
    run_phase(300, 22, 22);

    $display("ran %0d ticks (%0d scripted), %0d light updates compared field by field",
             ticks_sent, script.size(), updates_seen);
    $display("windows 5000, 0, 65535, 1 and random; free flow, sender gaps, receiver stalls");
    if (errors == 0)
      $display("PASS lighting_source_arbiter_top");
    else
      $display("FAIL lighting_source_arbiter_top");
    $finish;
  end

endmodule
